// ----- sv/pdr_pkg.sv -----
// Package for the deterministic particle resampler.
// Field widths, register addresses, controller states and the command and
// status bundles shared by the controller and the datapath.
package pdr_pkg;

   // Field widths
   localparam int WEIGHT_W = 17;   // unsigned Q1.16, 65536 is one
   localparam int IDX_W    = 6;    // particle and slot index
   localparam int CNT_W    = 7;    // particle count, up to 64
   localparam int COPY_W   = 8;    // copies of one particle, up to 128
   localparam int PROD_W   = WEIGHT_W + CNT_W;

   // Rounding constant for the copy count (one half in Q0.16)
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_PARTICLE_COUNT = 1'b0,
      REG_UNUSED         = 1'b1
   } pdr_reg_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_FILL
   } pdr_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // take a weight
      logic step;      // a result transaction completed
      logic sel_best;  // results come from the first maximum
      logic finish;    // set complete, clear set state
   } pdr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit_avail;  // copies pending and slots left
      logic full;        // all slots of the set filled
      logic last;        // current weight is the last of the set
   } pdr_status_type;

endpackage

// ----- sv/pdr_if.sv -----
// Channel interfaces of the deterministic particle resampler.
// Weight channel, result channel and APB-style register bus; uses pdr_pkg.
interface pdr_req_if;
   logic                          valid;
   logic                          ready;
   logic [pdr_pkg::WEIGHT_W-1:0] weight;

   modport source (output valid, output weight, input ready);
   modport sink (input valid, input weight, output ready);
endinterface

interface pdr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pdr_pkg::IDX_W-1:0] source_index;
   logic [pdr_pkg::IDX_W-1:0] slot_index;
   logic                       set_done;

   modport source (output valid, output source_index, output slot_index,
                   output set_done, input ready);
   modport sink (input valid, input source_index, input slot_index,
                 input set_done, output ready);
endinterface

interface pdr_csr_if;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [pdr_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pdr_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pdr_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   modport source (output psel, output penable, output pwrite, output paddr,
                   output pwdata, input prdata, input pready);
   modport sink (input psel, input penable, input pwrite, input paddr,
                 input pwdata, output prdata, output pready);
endinterface

// ----- sv/pdr_ctrl.sv -----
// Controller of the deterministic particle resampler.
// Sequences weight intake, copy emission and the final slot fill; uses pdr_pkg.
module pdr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pdr_pkg::pdr_status_type status,
   output pdr_pkg::pdr_cmd_type    cmd
);

   pdr_pkg::pdr_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdr_pkg::ST_IDLE: begin
            if (req_valid) state_in = pdr_pkg::ST_EMIT;
         end
         pdr_pkg::ST_EMIT: begin
            if (!status.emit_avail) begin
               state_in = status.last ? pdr_pkg::ST_FILL : pdr_pkg::ST_IDLE;
            end
         end
         pdr_pkg::ST_FILL: begin
            if (status.full) state_in = pdr_pkg::ST_IDLE;
         end
         default: state_in = pdr_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         pdr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pdr_pkg::ST_EMIT: begin
            rsp_valid = status.emit_avail;
            cmd.step  = status.emit_avail && rsp_ready;
         end
         pdr_pkg::ST_FILL: begin
            rsp_valid    = !status.full;
            cmd.sel_best = 1'b1;
            cmd.step     = !status.full && rsp_ready;
            cmd.finish   = status.full;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Intake and emission never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("pdr_ctrl: input ready while a result is offered");

   // A finished set always returns to intake
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("pdr_ctrl: no intake after set completion");

   // Filling only starts on the last weight of a set
   a_fill_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdr_pkg::ST_EMIT && state_in == pdr_pkg::ST_FILL) |-> status.last)
      else $error("pdr_ctrl: fill entered before the last weight");

endmodule

// ----- sv/pdr_dp.sv -----
// Datapath of the deterministic particle resampler.
// Count register, copy multiplier, slot counter and first-maximum tracker;
// uses pdr_pkg.
module pdr_dp #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pdr_pkg::pdr_cmd_type             cmd,
   output pdr_pkg::pdr_status_type          status,
   input  logic                             cfg_wr,
   input  logic [pdr_pkg::CNT_W-1:0]        cfg_count,
   output logic [pdr_pkg::CNT_W-1:0]        count_reg,
   input  logic [pdr_pkg::WEIGHT_W-1:0]     weight,
   output logic [pdr_pkg::IDX_W-1:0]        source_index,
   output logic [pdr_pkg::IDX_W-1:0]        slot_index,
   output logic                             set_done
);

   localparam int CW = pdr_pkg::CNT_W;
   localparam int PW = pdr_pkg::PROD_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTICLES);

   logic [CW-1:0]                count_ff, count_in;
   logic [pdr_pkg::IDX_W-1:0]    pos_ff, pos_in;
   logic [pdr_pkg::IDX_W-1:0]    cur_pos_ff, cur_pos_in;
   logic [CW-1:0]                slots_ff, slots_in;
   logic [pdr_pkg::COPY_W-1:0]   copies_ff, copies_in;
   logic                         last_ff, last_in;
   logic [pdr_pkg::WEIGHT_W-1:0] best_w_ff, best_w_in;
   logic [pdr_pkg::IDX_W-1:0]    best_pos_ff, best_pos_in;

   logic [CW-1:0] cnt_act;
   logic [PW-1:0] product;
   logic [PW-1:0] rounded;
   logic [CW-1:0] pos_next;
   logic [CW-1:0] slots_next;

   // Active count: zero means one, clamp at the maximum
   always_comb begin
      priority if (count_ff == '0) cnt_act = CW'(1);
      else if (count_ff > MAX_CNT) cnt_act = MAX_CNT;
      else                         cnt_act = count_ff;
   end

   // Copies = round(weight * count), half up
   assign product    = PW'(weight) * PW'(cnt_act);
   assign rounded    = product + pdr_pkg::ROUND_HALF;
   assign pos_next   = CW'(pos_ff) + CW'(1);
   assign slots_next = slots_ff + CW'(1);

   // Next-state logic
   always_comb begin
      count_in    = count_ff;
      pos_in      = pos_ff;
      cur_pos_in  = cur_pos_ff;
      slots_in    = slots_ff;
      copies_in   = copies_ff;
      last_in     = last_ff;
      best_w_in   = best_w_ff;
      best_pos_in = best_pos_ff;
      if (cmd.load) begin
         cur_pos_in = pos_ff;
         pos_in     = pos_next[pdr_pkg::IDX_W-1:0];
         copies_in  = rounded[PW-1:16];
         last_in    = (pos_next >= cnt_act);
         // First maximum: strict compare keeps the earliest
         if (pos_ff == '0 || weight > best_w_ff) begin
            best_w_in   = weight;
            best_pos_in = pos_ff;
         end
      end
      if (cmd.step) begin
         slots_in = slots_next;
         if (!cmd.sel_best) copies_in = copies_ff - pdr_pkg::COPY_W'(1);
      end
      if (cmd.finish || cfg_wr) begin
         pos_in      = '0;
         slots_in    = '0;
         best_w_in   = '0;
         best_pos_in = '0;
      end
      if (cfg_wr) count_in = cfg_count;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= pdr_pkg::COUNT_RESET;
         pos_ff      <= '0;
         slots_ff    <= '0;
         copies_ff   <= '0;
         best_w_ff   <= '0;
         best_pos_ff <= '0;
      end else begin
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         slots_ff    <= slots_in;
         copies_ff   <= copies_in;
         best_w_ff   <= best_w_in;
         best_pos_ff <= best_pos_in;
      end
   end

   // Per-item payload registers
   always_ff @(posedge clock) begin
      cur_pos_ff <= cur_pos_in;
      last_ff    <= last_in;
   end

   // Status and result fields
   assign status.emit_avail = (copies_ff != '0) && (slots_ff < cnt_act);
   assign status.full       = (slots_ff >= cnt_act);
   assign status.last       = last_ff;
   assign source_index      = cmd.sel_best ? best_pos_ff : cur_pos_ff;
   assign slot_index        = slots_ff[pdr_pkg::IDX_W-1:0];
   assign set_done          = (slots_next == cnt_act);
   assign count_reg         = count_ff;

   // Never more slots than particles
   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= cnt_act)
      else $error("pdr_dp: slot counter passed the particle count");

   // An emitted copy consumes a pending copy
   a_copy_pending: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !cmd.sel_best) |-> copies_ff != '0)
      else $error("pdr_dp: copy emitted with none pending");

   // Intake and emission are never commanded together
   a_load_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("pdr_dp: load and step in the same cycle");

endmodule

// ----- sv/particle_deterministic_resampler.sv -----
// Deterministic particle resampler, top level.
// Channels: req_ch carries one normalized weight (unsigned Q1.16) per
// transaction in particle order; rsp_ch returns one (source_index,
// slot_index, set_done) per filled slot of the new set; csr_bus is an
// APB-style port with particle_count at byte address 0.
// Each weight yields round(weight * count) copies of its index while slots
// remain. After the last weight of a set, remaining slots get the index of
// the first maximum weight, and set_done marks the final slot.
// Timing: a weight is taken while idle; any first result is offered the
// next cycle, and results then follow as rsp_ch takes them, until no copy
// is pending or no slot is left. After the last weight of a set, the fill
// state ends the set once all slots are full. The controller works on one
// weight at a time; req_ch is ready only while no result is pending.
// Reset (synchronous, active high) sets particle_count to 64 and clears the
// set. Writing particle_count restarts the set; write only while idle.
// A stalled rsp_ch holds the current result and the block waits.
module particle_deterministic_resampler #(
   parameter int MAX_PARTICLES = 64
) (
   input logic          clock,
   input logic          reset,
   pdr_req_if.sink      req_ch,
   pdr_rsp_if.source    rsp_ch,
   pdr_csr_if.sink      csr_bus
);

   pdr_pkg::pdr_cmd_type    cmd;
   pdr_pkg::pdr_status_type status;
   logic                         cfg_wr;
   logic [pdr_pkg::CNT_W-1:0]    count_reg;
   pdr_pkg::pdr_reg_type         reg_sel;

   // Register decode
   assign reg_sel = pdr_pkg::pdr_reg_type'(csr_bus.paddr[2]);
   assign cfg_wr  = csr_bus.psel && csr_bus.penable && csr_bus.pwrite
                    && (reg_sel == pdr_pkg::REG_PARTICLE_COUNT);
   assign csr_bus.pready = 1'b1;
   assign csr_bus.prdata = (reg_sel == pdr_pkg::REG_PARTICLE_COUNT)
                           ? pdr_pkg::CSR_DATA_W'(count_reg) : '0;

   pdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdr_dp #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg_wr       (cfg_wr),
      .cfg_count    (csr_bus.pwdata[pdr_pkg::CNT_W-1:0]),
      .count_reg    (count_reg),
      .weight       (req_ch.weight),
      .source_index (rsp_ch.source_index),
      .slot_index   (rsp_ch.slot_index),
      .set_done     (rsp_ch.set_done)
   );

endmodule
